FILE: hdl/normalized_convolution_3x3_rgb_macros.svh
// Assertion macros shared by the normalized 3x3 convolution RTL.
// Depends on nothing; the bodies vanish when SYNTH is defined.
`ifndef NORMALIZED_CONVOLUTION_3X3_RGB_MACROS_SVH
`define NORMALIZED_CONVOLUTION_3X3_RGB_MACROS_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset
`define NCV_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition implies a consequence in the same cycle or later
`define NCV_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define NCV_ASSERT(lbl, clk, rst, prop, msg)
`define NCV_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: hdl/ncv_pkg.sv
// Package of the normalized 3x3 convolution: types and fixed constants.
// Used by the top level and the divider; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ncv_pkg;
   // Fixed field widths
   localparam int PIX_BITS  = 8;
   localparam int SIZE_BITS = 11;
   localparam int POS_BITS  = 16;
   localparam int CSR_IDX_BITS = 3;
   localparam int QUO_BITS  = 8;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WEIGHTS_TOP   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WEIGHTS_MID   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WEIGHTS_BOT   = 3'd4;

   // Reset sizes
   localparam logic [SIZE_BITS-1:0] RESET_WIDTH  = 11'd640;
   localparam logic [SIZE_BITS-1:0] RESET_HEIGHT = 11'd480;

   // Input kinds
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADDR,
      ST_ACC,
      ST_START,
      ST_DIV
   } state_type;
endpackage
`default_nettype wire

FILE: hdl/ncv_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module ncv_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2052
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

FILE: hdl/ncv_div.sv
// Three-lane restoring divider: one quotient bit per cycle, clamped to 0..255.
// Depends on ncv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ncv_div #(
   parameter int ACC_W  = 21,
   parameter int WSUM_W = 12
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic signed [ACC_W-1:0]   sums [3],
   input  wire logic signed [WSUM_W-1:0]  wsum,
   output logic                           busy,
   output logic [ncv_pkg::QUO_BITS-1:0]   quotient [3]
);
   logic                               busy_ff, busy_in;
   logic [2:0]                         step_ff, step_in;
   logic [WSUM_W-1:0]                  dvs_ff, dvs_in;
   logic [ACC_W-1:0]                   rem_ff [3];
   logic [ACC_W-1:0]                   rem_in [3];
   logic [ncv_pkg::QUO_BITS-1:0]       q_ff [3];
   logic [ncv_pkg::QUO_BITS-1:0]       q_in [3];
   logic [2:0]                         zero_ff, zero_in, sat_ff, sat_in;
   logic                               wneg;
   logic [WSUM_W-1:0]                  dabs;
   logic [ACC_W-1:0]                   nabs [3];
   logic [ACC_W-1:0]                   dshift;

   // Load operands on start, then resolve one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      dvs_in  = dvs_ff;
      zero_in = zero_ff;
      sat_in  = sat_ff;
      wneg    = wsum < 0;
      if (wsum == '0) begin
         dabs = WSUM_W'(1);
      end else if (wneg) begin
         dabs = WSUM_W'(-wsum);
      end else begin
         dabs = WSUM_W'(wsum);
      end
      dshift = ACC_W'(dvs_ff) << step_ff;
      for (int ch = 0; ch < 3; ch++) begin
         nabs[ch] = (sums[ch] < 0) ? ACC_W'(-sums[ch]) : ACC_W'(sums[ch]);
         rem_in[ch] = rem_ff[ch];
         q_in[ch]   = q_ff[ch];
      end
      if (start) begin
         busy_in = 1'b1;
         step_in = 3'd7;
         dvs_in  = dabs;
         for (int ch = 0; ch < 3; ch++) begin
            zero_in[ch] = (sums[ch] == '0) || ((sums[ch] < 0) != wneg);
            sat_in[ch]  = nabs[ch] >= (ACC_W'(dabs) << ncv_pkg::QUO_BITS);
            rem_in[ch]  = nabs[ch];
            q_in[ch]    = '0;
         end
      end else if (busy_ff) begin
         for (int ch = 0; ch < 3; ch++) begin
            if (rem_ff[ch] >= dshift) begin
               rem_in[ch] = rem_ff[ch] - dshift;
               q_in[ch][step_ff] = 1'b1;
            end
         end
         step_in = step_ff - 3'd1;
         if (step_ff == 3'd0) begin
            busy_in = 1'b0;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      dvs_ff  <= dvs_in;
      zero_ff <= zero_in;
      sat_ff  <= sat_in;
      for (int ch = 0; ch < 3; ch++) begin
         rem_ff[ch] <= rem_in[ch];
         q_ff[ch]   <= q_in[ch];
      end
   end

   // Apply sign and clamp
   always_comb begin
      busy = busy_ff;
      for (int ch = 0; ch < 3; ch++) begin
         if (zero_ff[ch]) begin
            quotient[ch] = '0;
         end else if (sat_ff[ch]) begin
            quotient[ch] = '1;
         end else begin
            quotient[ch] = q_ff[ch];
         end
      end
   end
endmodule
`default_nettype wire

FILE: hdl/normalized_convolution_3x3_rgb.sv
// Normalized 3x3 RGB convolution: one pixel history RAM, tap sequencer and divider.
// Depends on ncv_pkg, ncv_ram, ncv_div and the assertion macro header.
//
// Pixels enter in raster order and results leave W+1 items behind; W+1 drain
// items (tuser high) flush the tail of a frame. An item that yields no result
// is handled in the idle state alone. For an item that yields a result, the nine
// neighbours are read from the one-write, one-read history RAM one at a time,
// each with an address step, then a multiply-accumulate step, then the three channel
// quotients come out of a shared restoring divider at one bit per cycle.
// The finished result sits in an output register, so the next item is taken
// while it waits. The history RAM needs no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "normalized_convolution_3x3_rgb_macros.svh"
module normalized_convolution_3x3_rgb #(
   parameter int MAX_WIDTH   = 1024,
   parameter int MAX_HEIGHT  = 1024,
   parameter int WEIGHT_BITS = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [23:0]                          req_tdata,  // in_red, in_green, in_blue
   input  wire logic                                 req_tuser,  // op
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [23:0]                               rsp_tdata,  // out_red, out_green, out_blue
   output logic                                      rsp_tlast,  // frame_last
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [ncv_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire logic [3*WEIGHT_BITS-1:0]             csr_wdata
);
   localparam int HIST     = 2 * MAX_WIDTH + 4;
   localparam int ADDR_W   = $clog2(HIST);
   localparam int PEND_W   = $clog2(HIST + 1);
   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int ROW_W    = $clog2(MAX_HEIGHT);
   localparam int ROW_BITS = 3 * WEIGHT_BITS;
   localparam int ACC_W    = WEIGHT_BITS + 13;
   localparam int WSUM_W   = WEIGHT_BITS + 4;
   localparam int PB       = ncv_pkg::POS_BITS;
   localparam int SB       = ncv_pkg::SIZE_BITS;
   localparam logic [ROW_BITS-1:0] WEIGHT_ONES =
      {3{{(WEIGHT_BITS - 1){1'b0}}, 1'b1}};

   // Configuration
   logic [SB-1:0]       width_ff, height_ff;
   logic [ROW_BITS-1:0] wrow_ff [3];
   logic [SB-1:0]       w, h;

   // Control and datapath state
   ncv_pkg::state_type        state_ff, state_in;
   logic [ADDR_W-1:0]         wp_ff, wp_in;
   logic [PEND_W-1:0]         pend_ff, pend_in, pend_inc;
   logic [COL_W-1:0]          col_ff, col_in;
   logic [ROW_W-1:0]          row_ff, row_in;
   logic [1:0]                trow_ff, trow_in, tcol_ff, tcol_in;
   logic                      tap_ok_ff, tap_ok_in;
   logic [WEIGHT_BITS-1:0]    wt_ff, wt_in;
   logic signed [ACC_W-1:0]   acc_ff [3];
   logic signed [ACC_W-1:0]   acc_in [3];
   logic signed [WSUM_W-1:0]  wsum_ff, wsum_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [23:0]               rsp_data_ff, rsp_data_in;
   logic                      rsp_last_ff, rsp_last_in;

   // Combinational helpers
   logic                      req_take, emit, load, ram_we, ram_re, div_start, div_busy;
   logic [ADDR_W-1:0]         ram_raddr;
   logic [23:0]               ram_rdata;
   logic signed [PB-1:0]      w_s, h_s, centre, dr, dc, rr, cc, off, addr_s;
   logic [ROW_BITS-1:0]       wrow_sel;
   logic signed [WEIGHT_BITS+8:0] prod [3];
   logic [ncv_pkg::QUO_BITS-1:0]  quo [3];
   logic [COL_W:0]            col_next;
   logic [ROW_W:0]            row_next;

   // Clamp frame sizes to 1..maximum
   always_comb begin
      if (width_ff == '0) begin
         w = SB'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w = SB'(MAX_WIDTH);
      end else begin
         w = width_ff;
      end
      if (height_ff == '0) begin
         h = SB'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h = SB'(MAX_HEIGHT);
      end else begin
         h = height_ff;
      end
   end

   // Configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ncv_pkg::RESET_WIDTH;
         height_ff <= ncv_pkg::RESET_HEIGHT;
         for (int i = 0; i < 3; i++) begin
            wrow_ff[i] <= WEIGHT_ONES;
         end
      end else if (csr_valid) begin
         case (csr_index)
            ncv_pkg::CSR_FRAME_WIDTH:  width_ff   <= csr_wdata[SB-1:0];
            ncv_pkg::CSR_FRAME_HEIGHT: height_ff  <= csr_wdata[SB-1:0];
            ncv_pkg::CSR_WEIGHTS_TOP:  wrow_ff[0] <= csr_wdata;
            ncv_pkg::CSR_WEIGHTS_MID:  wrow_ff[1] <= csr_wdata;
            ncv_pkg::CSR_WEIGHTS_BOT:  wrow_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Tap address: neighbour offset from the centre, wrapped into the ring
   always_comb begin
      w_s = $signed(PB'(w));
      h_s = $signed(PB'(h));
      centre = $signed(PB'(wp_ff)) - $signed(PB'(pend_ff));
      if (centre < 0) begin
         centre = centre + PB'(HIST);
      end
      dr = $signed(PB'(trow_ff)) - PB'(1);
      dc = $signed(PB'(tcol_ff)) - PB'(1);
      rr = $signed(PB'(row_ff)) + dr;
      cc = $signed(PB'(col_ff)) + dc;
      case (trow_ff)
         2'd0:    off = dc - w_s;
         2'd2:    off = dc + w_s;
         default: off = dc;
      endcase
      addr_s = centre + off;
      if (addr_s < 0) begin
         addr_s = addr_s + PB'(HIST);
      end else if (addr_s >= PB'(HIST)) begin
         addr_s = addr_s - PB'(HIST);
      end
      ram_raddr = ADDR_W'(addr_s);
      wrow_sel = wrow_ff[trow_ff];
      wt_in = wrow_sel[tcol_ff * WEIGHT_BITS +: WEIGHT_BITS];
      tap_ok_in = (rr >= 0) && (rr < h_s) && (cc >= 0) && (cc < w_s);
      for (int ch = 0; ch < 3; ch++) begin
         prod[ch] = $signed(wt_ff) *
                    $signed({1'b0, ram_rdata[ch * ncv_pkg::PIX_BITS +: ncv_pkg::PIX_BITS]});
      end
   end

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      pend_in      = pend_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      trow_in      = trow_ff;
      tcol_in      = tcol_ff;
      wsum_in      = wsum_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      for (int ch = 0; ch < 3; ch++) begin
         acc_in[ch] = acc_ff[ch];
      end
      req_tready = 1'b0;
      req_take   = 1'b0;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      div_start  = 1'b0;
      load       = 1'b0;
      emit       = 1'b0;
      pend_inc   = (32'(pend_ff) < HIST) ? pend_ff + PEND_W'(1) : pend_ff;
      col_next   = {1'b0, col_ff} + (COL_W + 1)'(1);
      row_next   = {1'b0, row_ff} + (ROW_W + 1)'(1);
      case (state_ff)
         ncv_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            req_take   = req_tvalid;
            if (req_take) begin
               if (req_tuser == ncv_pkg::OP_PIXEL) begin
                  ram_we  = 1'b1;
                  wp_in   = (32'(wp_ff) == HIST - 1) ? '0 : wp_ff + ADDR_W'(1);
                  pend_in = pend_inc;
                  emit    = 32'(pend_inc) >= 32'(w) + 32'd2;
               end else begin
                  emit = pend_ff != '0;
               end
               if (emit) begin
                  trow_in = 2'd0;
                  tcol_in = 2'd0;
                  wsum_in = '0;
                  for (int ch = 0; ch < 3; ch++) begin
                     acc_in[ch] = '0;
                  end
                  state_in = ncv_pkg::ST_ADDR;
               end
            end
         end
         ncv_pkg::ST_ADDR: begin
            ram_re   = tap_ok_in;
            state_in = ncv_pkg::ST_ACC;
         end
         ncv_pkg::ST_ACC: begin
            if (tap_ok_ff) begin
               wsum_in = wsum_ff + WSUM_W'($signed(wt_ff));
               for (int ch = 0; ch < 3; ch++) begin
                  acc_in[ch] = acc_ff[ch] + ACC_W'(prod[ch]);
               end
            end
            if (tcol_ff == 2'd2) begin
               tcol_in = 2'd0;
               trow_in = trow_ff + 2'd1;
            end else begin
               tcol_in = tcol_ff + 2'd1;
            end
            if ((tcol_ff == 2'd2) && (trow_ff == 2'd2)) begin
               state_in = ncv_pkg::ST_START;
            end else begin
               state_in = ncv_pkg::ST_ADDR;
            end
         end
         ncv_pkg::ST_START: begin
            div_start = 1'b1;
            state_in  = ncv_pkg::ST_DIV;
         end
         ncv_pkg::ST_DIV: begin
            if (!div_busy && (!rsp_valid_ff || rsp_tready)) begin
               load         = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {quo[2], quo[1], quo[0]};
               rsp_last_in  = (32'(row_ff) == 32'(h) - 32'd1) &&
                              (32'(col_ff) == 32'(w) - 32'd1);
               pend_in = pend_ff - PEND_W'(1);
               if (32'(col_next) >= 32'(w)) begin
                  col_in = '0;
                  row_in = (32'(row_next) >= 32'(h)) ? '0 : row_next[ROW_W-1:0];
               end else begin
                  col_in = col_next[COL_W-1:0];
               end
               state_in = ncv_pkg::ST_IDLE;
            end
         end
         default: state_in = ncv_pkg::ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ncv_pkg::ST_IDLE;
         wp_ff        <= '0;
         pend_ff      <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         pend_ff      <= pend_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      trow_ff     <= trow_in;
      tcol_ff     <= tcol_in;
      tap_ok_ff   <= tap_ok_in;
      wt_ff       <= wt_in;
      wsum_ff     <= wsum_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      for (int ch = 0; ch < 3; ch++) begin
         acc_ff[ch] <= acc_in[ch];
      end
   end

   // Pixel history ring
   ncv_ram #(
      .WIDTH (24),
      .DEPTH (HIST)
   ) u_hist (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (req_tdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Shared divider
   ncv_div #(
      .ACC_W  (ACC_W),
      .WSUM_W (WSUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .sums     (acc_ff),
      .wsum     (wsum_ff),
      .busy     (div_busy),
      .quotient (quo)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `NCV_ASSERT(a_pend_bound, clock, reset, 32'(pend_ff) <= HIST, "pending count exceeds ring")
   `NCV_ASSERT_IMPL(a_load_pend, clock, reset, load, pend_ff != '0, "result with nothing pending")
   `NCV_ASSERT_IMPL(a_div_runs, clock, reset, state_ff == ncv_pkg::ST_START, ##1 div_busy, "divider idle after start")
   `NCV_ASSERT_IMPL(a_load_shows, clock, reset, load, ##1 rsp_tvalid, "loaded result not shown")
endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking bench for the normalized 3x3 RGB convolution stream block.
// Depends on ncv_pkg and normalized_convolution_3x3_rgb; predicts filtered pixels, or takes a plan's answer.
`timescale 1ns / 1ps
module testbench;
   localparam int RING_DEPTH  = 2 * 1024 + 4;
   localparam int SETTLE      = 40;
   localparam int STALL_LIMIT = 5000;
   localparam int PIXEL_GOAL  = 1600;

   typedef struct {
      logic [23:0] rgb;
      logic        last;
   } pixel_out_type;

   // One directed frame: sizes, weights, pixel fill and, where obvious, the answer
   typedef struct {
      int          w;
      int          h;
      logic [23:0] wt;
      logic [23:0] wm;
      logic [23:0] wb;
      bit          rand_pix;
      logic [23:0] pix;
      int          want;   // -1: predictor, -2: same as pixel, else byte in every channel
   } frame_plan_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;
   logic req_tuser = ncv_pkg::OP_PIXEL;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [ncv_pkg::CSR_IDX_BITS-1:0] csr_index = ncv_pkg::CSR_FRAME_WIDTH;
   logic [23:0] csr_wdata = '0;

   // Predictor state
   logic [23:0] history [RING_DEPTH];
   bit          written [RING_DEPTH];
   int          wr_ptr, pending, out_row, out_col;
   logic [10:0] cfg_width, cfg_height;
   logic [23:0] weight_row [3];
   pixel_out_type filtered_q [$];

   int errors = 0;
   int mismatches = 0;
   int pixels_sent = 0;
   int send_idle_pct = 26;
   int recv_idle_pct = 60;
   int quiet_cycles = 0;

   normalized_convolution_3x3_rgb dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int eff_size(logic [10:0] v);
      if (v < 1) return 1;
      if (v > 1024) return 1024;
      return int'(v);
   endfunction

   function automatic logic [7:0] scale_channel(longint sum, longint wsum);
      longint q;
      if (sum == 0) return 8'd0;
      if ((sum < 0) != (wsum < 0)) return 8'd0;
      q = (sum < 0 ? -sum : sum) / (wsum < 0 ? -wsum : wsum);
      return q > 255 ? 8'd255 : q[7:0];
   endfunction

   // True when the next filtered pixel reads only history that has been written
   function automatic bit drain_is_safe();
      int w, h, centre, r, c, idx;
      w = eff_size(cfg_width);
      h = eff_size(cfg_height);
      if (pending == 0) return 1'b1;
      centre = (wr_ptr + RING_DEPTH - pending) % RING_DEPTH;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            r = out_row + dr;
            c = out_col + dc;
            idx = (centre + 2 * RING_DEPTH + dr * w + dc) % RING_DEPTH;
            if (r >= 0 && r < h && c >= 0 && c < w && !written[idx]) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // Advance the predictor by one item; returns 1 when a filtered pixel is due
   function automatic bit filter_step(logic op, logic [23:0] pix, output pixel_out_type res);
      int w, h, centre, r, c, idx;
      longint sums [3];
      longint wsum, wt;
      bit emit;
      w = eff_size(cfg_width);
      h = eff_size(cfg_height);
      sums = '{0, 0, 0};
      wsum = 0;
      if (op == ncv_pkg::OP_PIXEL) begin
         history[wr_ptr] = pix;
         written[wr_ptr] = 1'b1;
         wr_ptr = (wr_ptr + 1) % RING_DEPTH;
         if (pending < RING_DEPTH) pending++;
         emit = pending >= w + 2;
      end else begin
         emit = pending > 0;
      end
      if (!emit) return 1'b0;
      centre = (wr_ptr + RING_DEPTH - pending) % RING_DEPTH;
      for (int dr = -1; dr <= 1; dr++) begin
         r = out_row + dr;
         if (r < 0 || r >= h) continue;
         for (int dc = -1; dc <= 1; dc++) begin
            c = out_col + dc;
            if (c < 0 || c >= w) continue;
            idx = (centre + 2 * RING_DEPTH + dr * w + dc) % RING_DEPTH;
            wt = longint'($signed(weight_row[dr + 1][8 * (dc + 1) +: 8]));
            wsum += wt;
            for (int ch = 0; ch < 3; ch++)
               sums[ch] += wt * longint'(history[idx][8 * ch +: 8]);
         end
      end
      if (wsum == 0) wsum = 1;
      for (int ch = 0; ch < 3; ch++) res.rgb[8 * ch +: 8] = scale_channel(sums[ch], wsum);
      res.last = (out_row == h - 1 && out_col == w - 1);
      pending--;
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
         if (out_row >= h) out_row = 0;
      end
      return 1'b1;
   endfunction

   // Present one item, hold until taken, then queue what it yields
   task automatic send_item(logic op, logic [23:0] pix, int want);
      pixel_out_type res;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= pix;
      do @(posedge clock); while (!req_tready);
      if (op == ncv_pkg::OP_PIXEL) pixels_sent++;
      if (filter_step(op, pix, res)) begin
         if (want >= 0) res.rgb = {3{want[7:0]}};
         else if (want == -2) res.rgb = pix;
         filtered_q.push_back(res);
      end
   endtask

   task automatic write_reg(logic [ncv_pkg::CSR_IDX_BITS-1:0] idx, logic [23:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         ncv_pkg::CSR_FRAME_WIDTH:  cfg_width = val[10:0];
         ncv_pkg::CSR_FRAME_HEIGHT: cfg_height = val[10:0];
         ncv_pkg::CSR_WEIGHTS_TOP:  weight_row[0] = val;
         ncv_pkg::CSR_WEIGHTS_MID:  weight_row[1] = val;
         ncv_pkg::CSR_WEIGHTS_BOT:  weight_row[2] = val;
         default: ;
      endcase
   endtask

   // Drain the block, then load a new frame setting
   task automatic load_setting(logic [23:0] wv, logic [23:0] hv,
                               logic [23:0] t, logic [23:0] m, logic [23:0] b);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (filtered_q.size() != 0);
      repeat (SETTLE) @(posedge clock);
      write_reg(ncv_pkg::CSR_FRAME_WIDTH, wv);
      write_reg(ncv_pkg::CSR_FRAME_HEIGHT, hv);
      write_reg(ncv_pkg::CSR_WEIGHTS_TOP, t);
      write_reg(ncv_pkg::CSR_WEIGHTS_MID, m);
      write_reg(ncv_pkg::CSR_WEIGHTS_BOT, b);
      csr_valid <= 1'b0;
   endtask

   // Stream one whole frame and flush its tail
   task automatic run_frame(bit rand_pix, logic [23:0] pix, int want, bit noise);
      int w, h;
      logic [23:0] p;
      w = eff_size(cfg_width);
      h = eff_size(cfg_height);
      for (int i = 0; i < w * h; i++) begin
         // stray drains only where every neighbour they read has been written
         if (noise && drain_is_safe() && $urandom_range(0, 99) < 3)
            send_item(ncv_pkg::OP_DRAIN, 24'($urandom()), -1);
         p = rand_pix ? 24'($urandom()) : pix;
         send_item(ncv_pkg::OP_PIXEL, p, want);
         if (pixels_sent < PIXEL_GOAL / 3) begin
            send_idle_pct = 26; recv_idle_pct = 60;
         end else if (pixels_sent < 2 * PIXEL_GOAL / 3) begin
            send_idle_pct = 60; recv_idle_pct = 26;
         end else begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
      end
      for (int i = 0; i <= w; i++) send_item(ncv_pkg::OP_DRAIN, 24'($urandom()), -1);
   endtask

   function automatic logic [23:0] rand_weights();
      if ($urandom_range(0, 2) == 0) return 24'($urandom());
      return {8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)), 8'($urandom_range(0, 4))};
   endfunction

   // Receiver: compare each filtered pixel with the oldest prediction
   always @(posedge clock) begin
      pixel_out_type exp_px;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (filtered_q.size() == 0) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected pixel rgb=%h last=%b", rsp_tdata, rsp_tlast);
         end else begin
            exp_px = filtered_q.pop_front();
            for (int ch = 0; ch < 3; ch++) begin
               if (rsp_tdata[8 * ch +: 8] !== exp_px.rgb[8 * ch +: 8]) begin
                  errors++;
                  mismatches++;
                  if (mismatches <= 10)
                     $display("channel %0d: expected %h got %h", ch,
                              exp_px.rgb[8 * ch +: 8], rsp_tdata[8 * ch +: 8]);
               end
            end
            if (rsp_tlast !== exp_px.last) begin
               errors++;
               mismatches++;
               if (mismatches <= 10)
                  $display("frame_last: expected %b got %b", exp_px.last, rsp_tlast);
            end
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      frame_plan_type plan_rows [9];
      int phase;
      logic [23:0] wv, hv;
      plan_rows = '{
         '{3, 3, 24'h010101, 24'h010101, 24'h010101, 0, 24'hFFFFFF, 255},
         '{4, 2, 24'h000000, 24'h000000, 24'h000000, 0, 24'h808080, 0},
         '{2, 2, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 0, 24'h000000, 0},
         '{3, 2, 24'h808080, 24'h808080, 24'h808080, 0, 24'hFFFFFF, 255},
         '{1, 1, 24'h000000, 24'h000100, 24'h000000, 0, 24'hA5C35A, -2},
         '{4, 3, 24'h00FF01, 24'h01FF00, 24'hFF0001, 1, 24'h0, -1},
         '{5, 4, 24'h010101, 24'h010101, 24'h010101, 1, 24'h0, -1},
         '{3, 3, 24'hFF02FF, 24'h02F802, 24'hFF02FF, 1, 24'h0, -1},
         '{1, 4, 24'h7F8001, 24'h80017F, 24'h017F80, 1, 24'h0, -1}
      };
      for (int i = 0; i < RING_DEPTH; i++) begin
         history[i] = '0;
         written[i] = 1'b0;
      end
      wr_ptr = 0; pending = 0; out_row = 0; out_col = 0;
      cfg_width = ncv_pkg::RESET_WIDTH;
      cfg_height = ncv_pkg::RESET_HEIGHT;
      for (int i = 0; i < 3; i++) weight_row[i] = 24'h010101;

      // hold reset, then release
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames
      foreach (plan_rows[i]) begin
         load_setting(24'(plan_rows[i].w), 24'(plan_rows[i].h),
                      plan_rows[i].wt, plan_rows[i].wm, plan_rows[i].wb);
         run_frame(plan_rows[i].rand_pix, plan_rows[i].pix, plan_rows[i].want, 1'b0);
      end

      // random frames, with the tallest frame and out-of-range sizes along the way
      phase = 0;
      while (pixels_sent < PIXEL_GOAL) begin
         if (phase == 2) begin
            wv = 24'($urandom()) & 24'hFFF800;
            hv = 24'h7FF;
         end else begin
            wv = 24'($urandom_range(1, ($urandom_range(0, 5) == 0) ? 40 : 9))
                 | (24'($urandom()) & 24'hFFF800);
            hv = 24'($urandom_range(1, 6)) | (24'($urandom()) & 24'hFFF800);
         end
         load_setting(wv, hv, rand_weights(), rand_weights(), rand_weights());
         run_frame(1'b1, 24'h0, -1, 1'b1);
         phase++;
      end

      // let the last results come out
      req_tvalid <= 1'b0;
      do @(posedge clock); while (filtered_q.size() != 0);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end
endmodule
